// File: rtl/core/md5he_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package md5he_pkg;

   localparam int BLK_WORDS = 16;
   localparam int WIDX_W    = $clog2(BLK_WORDS);
   localparam int TOTAL_W   = 61;

   typedef logic [3:0][31:0] chain_type;

   typedef struct packed {
      logic start;   // load working vars from chain, run 64 rounds
      logic init;    // reload chain with the initial vector
   } cmp_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;    // one-cycle pulse on the chain update cycle
   } cmp_sts_type;

   localparam chain_type MD5_IV = {32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301};

   localparam logic [31:0] MD5_K [64] = '{
      32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
      32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
      32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
      32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
      32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
      32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
      32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
      32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
      32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
      32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
      32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
      32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
      32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
      32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
      32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
      32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
   };

   localparam logic [4:0] MD5_S [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // message word index used by round i
   function automatic logic [WIDX_W-1:0] md5_g(input logic [5:0] i);
      logic [3:0] lo;
      logic [3:0] g;
      begin
         lo = i[3:0];
         unique case (i[5:4])
            2'd0: g = lo;
            2'd1: g = 4'((lo << 2) + lo + 4'd1);
            2'd2: g = 4'((lo << 1) + lo + 4'd5);
            2'd3: g = 4'((lo << 3) - lo);
         endcase
         md5_g = g;
      end
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
      logic [63:0] dbl;
      begin
         dbl    = {x, x} << s;
         rotl32 = dbl[63:32];
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/md5he_block_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module md5he_block_mem (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [md5he_pkg::WIDX_W-1:0]  wr_addr,
   input  wire logic [31:0]                   wr_data,
   input  wire logic [md5he_pkg::WIDX_W-1:0]  rd_addr,
   output logic      [31:0]                   rd_data
);
   import md5he_pkg::*;

   logic [31:0] mem [BLK_WORDS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/core/md5he_compress.sv
`timescale 1ns / 1ps
`default_nettype none

module md5he_compress (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire md5he_pkg::cmp_ctl_type        ctl,
   input  wire logic [31:0]                   rd_data,
   output logic      [md5he_pkg::WIDX_W-1:0]  rd_addr,
   output md5he_pkg::cmp_sts_type             sts,
   output md5he_pkg::chain_type               chain
);
   import md5he_pkg::*;

   logic        run_ff;
   logic        add_ff;
   logic [5:0]  rnd_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   chain_type   chain_ff;

   logic [31:0] f_val;
   logic [31:0] t_sum;
   logic [31:0] b_in;
   logic [5:0]  rnd_nxt;

   always_comb begin
      unique case (rnd_ff[5:4])
         2'd0: f_val = d_ff ^ (b_ff & (c_ff ^ d_ff));
         2'd1: f_val = c_ff ^ (d_ff & (b_ff ^ c_ff));
         2'd2: f_val = b_ff ^ c_ff ^ d_ff;
         2'd3: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
      rnd_nxt = rnd_ff + 6'd1;
      t_sum   = a_ff + f_val + MD5_K[rnd_ff] + rd_data;
      b_in    = b_ff + rotl32(t_sum, MD5_S[{rnd_ff[5:4], rnd_ff[1:0]}]);
      // prefetch the word for the next round; word 0 while idle for round 0
      rd_addr = run_ff ? md5_g(rnd_nxt) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         add_ff   <= 1'b0;
         chain_ff <= MD5_IV;
      end else begin
         if (ctl.start) begin
            run_ff <= 1'b1;
         end else if (run_ff && rnd_ff == 6'd63) begin
            run_ff <= 1'b0;
         end
         add_ff <= run_ff && rnd_ff == 6'd63;
         if (ctl.init) begin
            chain_ff <= MD5_IV;
         end else if (add_ff) begin
            chain_ff[0] <= chain_ff[0] + a_ff;
            chain_ff[1] <= chain_ff[1] + b_ff;
            chain_ff[2] <= chain_ff[2] + c_ff;
            chain_ff[3] <= chain_ff[3] + d_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_ff <= '0;
      end else if (ctl.start) begin
         a_ff   <= chain_ff[0];
         b_ff   <= chain_ff[1];
         c_ff   <= chain_ff[2];
         d_ff   <= chain_ff[3];
         rnd_ff <= '0;
      end else if (run_ff) begin
         a_ff   <= d_ff;
         b_ff   <= b_in;
         c_ff   <= b_ff;
         d_ff   <= c_ff;
         rnd_ff <= rnd_nxt;
      end
   end

   assign sts.busy = run_ff | add_ff;
   assign sts.done = add_ff;
   assign chain    = chain_ff;

endmodule

`default_nettype wire

// File: rtl/core/md5_hash_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Ports                                        Moves
// req      in   req_valid/req_stall, data_word, byte_count,  one message word
//               last
// rsp      out  rsp_valid/rsp_stall, digest_word, digest_last one digest word
//
// Words are packed into a 16-entry block memory. Each full block then stalls the
// input while the round unit runs (64 rounds, one chain add; the load shares the
// cycle of the word that fills the block). The last word adds padding (plus a
// second block when the tail is past byte 55), the final compression and four
// digest transfers.
// Reset is synchronous; req_stall is high whenever the engine is not idle,
// and a stalled digest word holds until its transfer.

module md5_hash_engine_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_data_word,
   input  wire logic [2:0]  req_byte_count,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [31:0] rsp_digest_word,
   output logic             rsp_digest_last
);
   import md5he_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PAD   = 4'd1;
   localparam logic [3:0] S_ZERO  = 4'd2;
   localparam logic [3:0] S_LENLO = 4'd3;
   localparam logic [3:0] S_LENHI = 4'd4;
   localparam logic [3:0] S_COMP  = 4'd5;
   localparam logic [3:0] S_OUT   = 4'd6;

   localparam logic [WIDX_W-1:0] WIDX_LAST = WIDX_W'(BLK_WORDS - 1);
   localparam logic [WIDX_W-1:0] WIDX_LEN  = WIDX_W'(BLK_WORDS - 2);
   localparam logic [WIDX_W-1:0] WIDX_ONE  = WIDX_W'(1);

   logic [3:0]          state_ff, state_in;
   logic [3:0]          ret_ff, ret_in;
   logic [WIDX_W-1:0]   widx_ff, widx_in;
   logic [1:0]          bo_ff, bo_in;
   logic [31:0]         pend_ff, pend_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [1:0]          oidx_ff, oidx_in;

   cmp_ctl_type         ctl;
   cmp_sts_type         sts;
   chain_type           chain;
   logic [WIDX_W-1:0]   rd_addr;
   logic [31:0]         rd_data;

   logic                wr_en;
   logic [31:0]         wr_data;

   logic                req_xfer;
   logic                rsp_xfer;
   logic [2:0]          nbytes;
   logic [31:0]         data_kept;
   logic [31:0]         pend_kept;
   logic [63:0]         merged;
   logic [2:0]          off_sum;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   always_comb begin
      nbytes = (req_byte_count > 3'd4) ? 3'd4 : req_byte_count;
      for (int j = 0; j < 4; j++) begin
         data_kept[8*j +: 8] = (3'(j) < nbytes) ? req_data_word[8*j +: 8] : 8'h00;
         pend_kept[8*j +: 8] = (2'(j) < bo_ff) ? pend_ff[8*j +: 8] : 8'h00;
      end
      merged  = {32'h0, pend_kept} | ({32'h0, data_kept} << {bo_ff, 3'b000});
      off_sum = {1'b0, bo_ff} + nbytes;
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      widx_in   = widx_ff;
      bo_in     = bo_ff;
      pend_in   = pend_ff;
      total_in  = total_ff;
      oidx_in   = oidx_ff;
      wr_en     = 1'b0;
      wr_data   = merged[31:0];
      ctl.start = 1'b0;
      ctl.init  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               total_in = total_ff + TOTAL_W'(nbytes);
               bo_in    = off_sum[1:0];
               if (off_sum[2]) begin
                  wr_en   = 1'b1;
                  pend_in = merged[63:32];
                  widx_in = widx_ff + WIDX_ONE;
               end else begin
                  pend_in = merged[31:0];
               end
               if (off_sum[2] && widx_ff == WIDX_LAST) begin
                  ctl.start = 1'b1;
                  ret_in    = req_last ? S_PAD : S_IDLE;
                  state_in  = S_COMP;
               end else if (req_last) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            // 0x80 marker right after the last data byte, zeros above it
            wr_en   = 1'b1;
            wr_data = pend_kept | (32'h80 << {bo_ff, 3'b000});
            widx_in = widx_ff + WIDX_ONE;
            bo_in   = '0;
            if (widx_ff == WIDX_LAST) begin
               ctl.start = 1'b1;
               ret_in    = S_ZERO;
               state_in  = S_COMP;
            end else begin
               state_in = S_ZERO;
            end
         end
         S_ZERO: begin
            if (widx_ff == WIDX_LEN) begin
               state_in = S_LENLO;
            end else begin
               wr_en   = 1'b1;
               wr_data = '0;
               widx_in = widx_ff + WIDX_ONE;
               if (widx_ff == WIDX_LAST) begin
                  ctl.start = 1'b1;
                  ret_in    = S_ZERO;
                  state_in  = S_COMP;
               end
            end
         end
         S_LENLO: begin
            wr_en    = 1'b1;
            wr_data  = {total_ff[28:0], 3'b000};
            widx_in  = widx_ff + WIDX_ONE;
            state_in = S_LENHI;
         end
         S_LENHI: begin
            wr_en     = 1'b1;
            wr_data   = total_ff[60:29];
            widx_in   = widx_ff + WIDX_ONE;
            ctl.start = 1'b1;
            ret_in    = S_OUT;
            state_in  = S_COMP;
         end
         S_COMP: begin
            if (sts.done) begin
               state_in = ret_ff;
            end
         end
         S_OUT: begin
            if (rsp_xfer) begin
               oidx_in = oidx_ff + 2'd1;
               if (oidx_ff == 2'd3) begin
                  ctl.init = 1'b1;
                  total_in = '0;
                  widx_in  = '0;
                  bo_in    = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         widx_ff  <= '0;
         bo_ff    <= '0;
         total_ff <= '0;
         oidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         widx_ff  <= widx_in;
         bo_ff    <= bo_in;
         total_ff <= total_in;
         oidx_ff  <= oidx_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

   assign req_stall       = state_ff != S_IDLE;
   assign rsp_valid       = state_ff == S_OUT;
   assign rsp_digest_word = chain[oidx_ff];
   assign rsp_digest_last = oidx_ff == 2'd3;

   // the only fill that meets a round read writes word 15 while word 0 is read, so no forwarding is needed
   md5he_block_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (widx_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   md5he_compress u_cmp (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .rd_data (rd_data),
      .rd_addr (rd_addr),
      .sts     (sts),
      .chain   (chain)
   );

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !sts.busy)
      else $error("round unit started while busy");

   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      sts.busy |-> !wr_en)
      else $error("block memory written during compression");

   a_done_in_comp: assert property (@(posedge clock) disable iff (reset)
      sts.done |-> state_ff == S_COMP)
      else $error("compression finished outside wait state");

   a_len_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LENHI |-> widx_ff == WIDX_LAST)
      else $error("length high word not in last block slot");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_digest_last) |=> (total_ff == '0 && widx_ff == '0 && bo_ff == '0))
      else $error("message state not cleared after digest");

endmodule

`default_nettype wire
